// ===== rtl/spce_pkg.sv =====
package spce_pkg;

  localparam int CODE_DEPTH = 8192;
  localparam int DATA_DEPTH = 256;
  localparam int ID_DEPTH   = 8;
  localparam int CFG_DEPTH  = 16;
  localparam int MASK_COUNT = 16;

  localparam int CODE_AW = $clog2(CODE_DEPTH);
  localparam int DATA_AW = $clog2(DATA_DEPTH);
  localparam int ID_AW   = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;
  localparam int CFG_AW  = (CFG_DEPTH > 1) ? $clog2(CFG_DEPTH) : 1;
  localparam int MASK_AW = $clog2(MASK_COUNT);

  // clearing pass after reset covers the deeper of code and data
  localparam int CLR_DEPTH = (CODE_DEPTH > DATA_DEPTH) ? CODE_DEPTH : DATA_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  localparam int INFO_BYTES = 44;

  // command bytes
  localparam logic [7:0] CB_BLANK_CHECK = 8'h42;
  localparam logic [7:0] CB_WR_CODE     = 8'h51;
  localparam logic [7:0] CB_RD_CODE     = 8'h54;
  localparam logic [7:0] CB_RD_DATA     = 8'h64;
  localparam logic [7:0] CB_RD_ID       = 8'h65;
  localparam logic [7:0] CB_RD_CFG      = 8'h66;
  localparam logic [7:0] CB_WR_CFG      = 8'h67;
  localparam logic [7:0] CB_WR_ID       = 8'h68;
  localparam logic [7:0] CB_WR_DATA     = 8'h69;
  localparam logic [7:0] CB_WR_CFG_AT   = 8'h70;
  localparam logic [7:0] CB_HELLO       = 8'h80;
  localparam logic [7:0] CB_LOAD_INFO   = 8'h81;
  localparam logic [7:0] CB_LOAD_MASKS  = 8'h82;
  localparam logic [7:0] CB_PING        = 8'h88;
  localparam logic [7:0] CB_VERSION     = 8'h8d;
  localparam logic [7:0] CB_SET_RANGE   = 8'h8e;
  localparam logic [7:0] CB_ERASE       = 8'h8F;

  // fixed reply bytes
  localparam logic [7:0] RB_HELLO_ID  = 8'h2c;
  localparam logic [7:0] RB_PING      = 8'hab;
  localparam logic [7:0] RB_VER_MAJOR = 8'd4;
  localparam logic [7:0] RB_VER_MINOR = 8'd40;
  localparam logic [7:0] RB_VER_PATCH = 8'd12;
  localparam logic [7:0] RB_STATUS_OK = 8'h00;

  localparam logic [23:0] CFG_BASE_ADDR = 24'h300000;

  // blank check status bits
  localparam logic [3:0] ST_CODE = 4'h1;
  localparam logic [3:0] ST_CFG  = 4'h2;
  localparam logic [3:0] ST_ID   = 4'h4;
  localparam logic [3:0] ST_DATA = 4'h8;

  // register indexes
  localparam logic [1:0] REG_CODE_WORDS = 2'd0;
  localparam logic [1:0] REG_DATA_BYTES = 2'd1;
  localparam logic [1:0] REG_ID_WORDS   = 2'd2;
  localparam logic [1:0] REG_CFG_WORDS  = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       response_end;
    logic       target_reset;
  } out_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_BLANK, CMD_WR_CODE, CMD_RD_CODE, CMD_RD_DATA, CMD_RD_ID, CMD_RD_CFG,
    CMD_WR_CFG, CMD_WR_ID, CMD_WR_DATA, CMD_WR_CFG_AT, CMD_HELLO, CMD_LOAD_INFO,
    CMD_LOAD_MASKS, CMD_PING, CMD_VERSION, CMD_SET_RANGE, CMD_ERASE
  } cmd_t;

  typedef struct packed {
    in_t  item;
    cmd_t cmd;
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RANGE, PH_INFO, PH_MASKS, PH_WR_HI, PH_WR_LO, PH_WR_DATA,
    PH_RD_HI, PH_RD_LO, PH_RD_DATA
  } phase_t;

  typedef enum logic [1:0] {SP_CODE, SP_DATA, SP_ID, SP_CFG} space_t;

  typedef enum logic [2:0] {
    ENG_CLEAR, ENG_READY, ENG_RDWAIT, ENG_WALK, ENG_WFIN, ENG_EMIT
  } eng_state_t;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// ===== rtl/serial_programmer_command_engine_top.sv =====
// Device side of a byte-serial programmer protocol. Drive start with one beat
// (kind 0 = host byte, kind 1 = transmitter slot) while busy is low; results
// come out as one beat per cycle on out_valid and cannot be held off, so the
// receiver must take every beat. An ordinary beat passes the front register,
// the queue and the engine's ready state and gives up to four result beats; a
// read drain beat also passes an extra wait state, in which the registered
// read of the code or data RAM completes. Blank check and erase walk each
// space one word per cycle before their two reply beats. After reset busy
// stays high for a clearing pass over max(CODE_DEPTH, DATA_DEPTH) addresses
// (8192 as built) that zeroes the code and data RAMs; configuration writes on
// cfg_we are taken at any time and only change the sizes in use.
module serial_programmer_command_engine_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  spce_pkg::in_t   in_item,
  output logic            out_valid,
  output spce_pkg::out_t  out_item,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [13:0]     cfg_wdata
);

  logic                accept;
  logic                push, front_pending, pop, eng_idle;
  spce_pkg::op_t       push_op, head;
  spce_pkg::q_status_t q_st;

  // one beat in flight at a time: front, queue and engine must all be empty
  assign busy   = front_pending || q_st.valid || !eng_idle;
  assign accept = start && !busy;

  spce_front u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .in_item(in_item),
    .q_full(q_st.full), .push(push), .push_op(push_op), .pending(front_pending)
  );

  spce_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_op(push_op),
    .pop(pop), .head(head), .status(q_st)
  );

  spce_engine u_engine (
    .clk(clk), .rst_n(rst_n), .op_valid(q_st.valid), .op(head), .op_pop(pop),
    .idle(eng_idle), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_item(out_item)
  );

endmodule

// ===== rtl/spce_ram.sv =====
module spce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/spce_front.sv =====
module spce_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  spce_pkg::in_t     in_item,
  input  logic              q_full,
  output logic              push,
  output spce_pkg::op_t     push_op,
  output logic              pending
);

  logic          v_r;
  spce_pkg::op_t op_r;

  function automatic spce_pkg::cmd_t decode(input logic [7:0] b);
    spce_pkg::cmd_t c;
    case (b)
      spce_pkg::CB_BLANK_CHECK: c = spce_pkg::CMD_BLANK;
      spce_pkg::CB_WR_CODE:     c = spce_pkg::CMD_WR_CODE;
      spce_pkg::CB_RD_CODE:     c = spce_pkg::CMD_RD_CODE;
      spce_pkg::CB_RD_DATA:     c = spce_pkg::CMD_RD_DATA;
      spce_pkg::CB_RD_ID:       c = spce_pkg::CMD_RD_ID;
      spce_pkg::CB_RD_CFG:      c = spce_pkg::CMD_RD_CFG;
      spce_pkg::CB_WR_CFG:      c = spce_pkg::CMD_WR_CFG;
      spce_pkg::CB_WR_ID:       c = spce_pkg::CMD_WR_ID;
      spce_pkg::CB_WR_DATA:     c = spce_pkg::CMD_WR_DATA;
      spce_pkg::CB_WR_CFG_AT:   c = spce_pkg::CMD_WR_CFG_AT;
      spce_pkg::CB_HELLO:       c = spce_pkg::CMD_HELLO;
      spce_pkg::CB_LOAD_INFO:   c = spce_pkg::CMD_LOAD_INFO;
      spce_pkg::CB_LOAD_MASKS:  c = spce_pkg::CMD_LOAD_MASKS;
      spce_pkg::CB_PING:        c = spce_pkg::CMD_PING;
      spce_pkg::CB_VERSION:     c = spce_pkg::CMD_VERSION;
      spce_pkg::CB_SET_RANGE:   c = spce_pkg::CMD_SET_RANGE;
      spce_pkg::CB_ERASE:       c = spce_pkg::CMD_ERASE;
      default:                  c = spce_pkg::CMD_NONE;
    endcase
    return c;
  endfunction

  assign push    = v_r && !q_full;
  assign push_op = op_r;
  assign pending = v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= 1'b1;
    end else if (push) begin
      v_r <= 1'b0;
    end
  end

  // slot beats carry no command; decode is only used for bytes seen in idle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r.item <= in_item;
      op_r.cmd  <= in_item.kind ? spce_pkg::CMD_NONE : decode(in_item.rx_byte);
    end
  end

endmodule

// ===== rtl/spce_queue.sv =====
module spce_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  spce_pkg::op_t        push_op,
  input  logic                 pop,
  output spce_pkg::op_t        head,
  output spce_pkg::q_status_t  status
);

  localparam int PW = $clog2(spce_pkg::QUEUE_DEPTH);

  spce_pkg::op_t  ent_r [spce_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    cnt_r;

  assign head         = ent_r[rp_r];
  assign status.valid = (cnt_r != '0);
  assign status.full  = (cnt_r == (PW+1)'(spce_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_op;
    end
  end

endmodule

// ===== rtl/spce_engine.sv =====
module spce_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 op_valid,
  input  spce_pkg::op_t        op,
  output logic                 op_pop,
  output logic                 idle,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [13:0]          cfg_wdata,
  output logic                 out_valid,
  output spce_pkg::out_t       out_item
);

  localparam int CAW = spce_pkg::CODE_AW;
  localparam int DAW = spce_pkg::DATA_AW;
  localparam int IAW = spce_pkg::ID_AW;
  localparam int FAW = spce_pkg::CFG_AW;
  localparam int MAW = spce_pkg::MASK_AW;

  spce_pkg::eng_state_t state_r, state_nxt;
  spce_pkg::phase_t     phase_r, phase_nxt;
  spce_pkg::space_t     sp_r, sp_nxt;
  logic [5:0]           pc_r, pc_nxt;
  logic [23:0]          rs_r, rs_nxt;
  logic [15:0]          rl_r, rl_nxt;
  logic [7:0]           pend_r, pend_nxt;
  logic [15:0]          wl_r, wl_nxt;
  logic [23:0]          cptr_r, cptr_nxt;
  logic [15:0]          dptr_r, dptr_nxt;
  logic [7:0]           iptr_r, iptr_nxt;
  logic [23:0]          fptr_r, fptr_nxt;

  // the processor info bytes that matter
  logic [15:0] code_len_r, code_len_nxt;
  logic [15:0] bcode_r, bcode_nxt;
  logic [15:0] bid_r, bid_nxt;
  logic [15:0] bdata_r, bdata_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic [7:0]  idlen_r, idlen_nxt;
  logic [7:0]  cfglen_r, cfglen_nxt;

  logic [13:0] code_use_r;
  logic [8:0]  data_use_r;
  logic [3:0]  id_use_r;
  logic [4:0]  cfgw_use_r;

  logic [15:0] mask_r [spce_pkg::MASK_COUNT];
  logic [15:0] id_r   [spce_pkg::ID_DEPTH];
  logic [15:0] cfgs_r [spce_pkg::CFG_DEPTH];

  spce_pkg::out_t obuf_r [4];
  spce_pkg::out_t obuf_nxt [4];
  logic [2:0]     ocnt_r, ocnt_nxt;

  // memory walk
  logic             werase_r, werase_nxt;
  spce_pkg::space_t wsp_r, wsp_nxt;
  logic [15:0]      wix_r, wix_nxt;
  logic [3:0]       wst_r, wst_nxt;
  logic             chk_v_r, chk_v_nxt;

  // pending read
  spce_pkg::space_t rd_sp_r, rd_sp_nxt;
  logic             rd_inr_r, rd_inr_nxt;
  logic [7:0]       rd_ix_r, rd_ix_nxt;

  logic [CLR_W_L-1:0] clr_r, clr_nxt;
  localparam int CLR_W_L = spce_pkg::CLR_W;

  // memory ports
  logic           code_we;
  logic [CAW-1:0] code_waddr, code_raddr;
  logic [15:0]    code_wdata, code_rdata;
  logic           data_we;
  logic [DAW-1:0] data_waddr, data_raddr;
  logic [7:0]     data_wdata, data_rdata;

  logic           id_we;
  logic [IAW-1:0] id_wi;
  logic [15:0]    id_wd;
  logic           cst_we;
  logic [FAW-1:0] cst_wi;
  logic [15:0]    cst_wd;
  logic           mask_we, mask_hi;
  logic [MAW-1:0] mask_wi;
  logic [7:0]     mask_wb;

  logic [16:0] lim_c, lim_d, lim_i, lim_f;
  logic        inr_c, inr_d, inr_i, inr_f;
  logic        winr;
  logic [15:0] wn;
  logic [15:0] rv, rblank, mask_rd, mask_wk;
  logic [15:0] room, ccount;
  logic [23:0] cfg_off;
  logic [7:0]  b;

  spce_ram #(.WIDTH(16), .DEPTH(spce_pkg::CODE_DEPTH)) u_code (
    .clk(clk), .we(code_we), .waddr(code_waddr), .wdata(code_wdata),
    .raddr(code_raddr), .rdata(code_rdata)
  );

  spce_ram #(.WIDTH(8), .DEPTH(spce_pkg::DATA_DEPTH)) u_data (
    .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
    .raddr(data_raddr), .rdata(data_rdata)
  );

  function automatic spce_pkg::out_t mk(input logic [7:0] v, input logic e);
    spce_pkg::out_t o;
    o.tx_byte      = v;
    o.response_end = e;
    o.target_reset = e;
    return o;
  endfunction

  // sizes in use
  always_comb begin
    lim_c = ({3'b0, code_use_r} < 17'(spce_pkg::CODE_DEPTH)) ? {3'b0, code_use_r}
                                                             : 17'(spce_pkg::CODE_DEPTH);
    lim_d = ({8'b0, data_use_r} < 17'(spce_pkg::DATA_DEPTH)) ? {8'b0, data_use_r}
                                                             : 17'(spce_pkg::DATA_DEPTH);
    lim_i = ({13'b0, id_use_r} < 17'(spce_pkg::ID_DEPTH)) ? {13'b0, id_use_r}
                                                          : 17'(spce_pkg::ID_DEPTH);
    lim_f = ({12'b0, cfgw_use_r} < 17'(spce_pkg::CFG_DEPTH)) ? {12'b0, cfgw_use_r}
                                                             : 17'(spce_pkg::CFG_DEPTH);
    inr_c = {1'b0, cptr_r} < {8'b0, lim_c};
    inr_d = {1'b0, dptr_r} < lim_d;
    inr_i = {9'b0, iptr_r} < lim_i;
    inr_f = {1'b0, fptr_r} < {8'b0, lim_f};
  end

  // read value of the pending access and what it must match when blank checking
  always_comb begin
    mask_rd = (rd_ix_r < 8'(spce_pkg::MASK_COUNT)) ? mask_r[rd_ix_r[MAW-1:0]] : 16'h0;
    mask_wk = (wix_r < 16'(spce_pkg::MASK_COUNT)) ? mask_r[wix_r[MAW-1:0]] : 16'h0;
    case (rd_sp_r)
      spce_pkg::SP_CODE: begin
        rv     = rd_inr_r ? code_rdata : 16'h0;
        rblank = bcode_r;
      end
      spce_pkg::SP_DATA: begin
        rv     = rd_inr_r ? {8'b0, data_rdata} : 16'h0;
        rblank = bdata_r;
      end
      spce_pkg::SP_ID: begin
        rv     = rd_inr_r ? id_r[rd_ix_r[IAW-1:0]] : 16'h0;
        rblank = bid_r;
      end
      default: begin
        rv     = rd_inr_r ? cfgs_r[rd_ix_r[FAW-1:0]] : 16'h0;
        rblank = mask_rd;
      end
    endcase
  end

  // walk length and bounds for the current space
  always_comb begin
    case (wsp_r)
      spce_pkg::SP_CODE: begin
        wn   = code_len_r;
        winr = {1'b0, wix_r} < lim_c;
      end
      spce_pkg::SP_DATA: begin
        wn   = dlen_r;
        winr = {1'b0, wix_r} < lim_d;
      end
      spce_pkg::SP_ID: begin
        wn   = {8'b0, idlen_r};
        winr = {1'b0, wix_r} < lim_i;
      end
      default: begin
        wn   = {8'b0, cfglen_r};
        winr = {1'b0, wix_r} < lim_f;
      end
    endcase
  end

  always_comb begin
    room    = code_len_r - rs_r[15:0];
    ccount  = (rs_r >= {8'b0, code_len_r}) ? 16'h0 : ((rl_r < room) ? rl_r : room);
    cfg_off = rs_r - spce_pkg::CFG_BASE_ADDR;
  end

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    sp_nxt       = sp_r;
    pc_nxt       = pc_r;
    rs_nxt       = rs_r;
    rl_nxt       = rl_r;
    pend_nxt     = pend_r;
    wl_nxt       = wl_r;
    cptr_nxt     = cptr_r;
    dptr_nxt     = dptr_r;
    iptr_nxt     = iptr_r;
    fptr_nxt     = fptr_r;
    code_len_nxt = code_len_r;
    bcode_nxt    = bcode_r;
    bid_nxt      = bid_r;
    bdata_nxt    = bdata_r;
    dlen_nxt     = dlen_r;
    idlen_nxt    = idlen_r;
    cfglen_nxt   = cfglen_r;
    obuf_nxt     = obuf_r;
    ocnt_nxt     = ocnt_r;
    werase_nxt   = werase_r;
    wsp_nxt      = wsp_r;
    wix_nxt      = wix_r;
    wst_nxt      = wst_r;
    chk_v_nxt    = 1'b0;
    rd_sp_nxt    = rd_sp_r;
    rd_inr_nxt   = rd_inr_r;
    rd_ix_nxt    = rd_ix_r;
    clr_nxt      = clr_r;
    op_pop       = 1'b0;
    code_we      = 1'b0;
    code_waddr   = cptr_r[CAW-1:0];
    code_wdata   = {pend_r, op.item.rx_byte};
    code_raddr   = cptr_r[CAW-1:0];
    data_we      = 1'b0;
    data_waddr   = dptr_r[DAW-1:0];
    data_wdata   = op.item.rx_byte;
    data_raddr   = dptr_r[DAW-1:0];
    id_we        = 1'b0;
    id_wi        = iptr_r[IAW-1:0];
    id_wd        = {pend_r, op.item.rx_byte};
    cst_we       = 1'b0;
    cst_wi       = fptr_r[FAW-1:0];
    cst_wd       = {pend_r, op.item.rx_byte};
    mask_we      = 1'b0;
    mask_hi      = !pc_r[0];
    mask_wi      = pc_r[MAW:1];
    mask_wb      = op.item.rx_byte;
    b            = op.item.rx_byte;

    // blank check compare stage, in the cycle after the walk address
    if (chk_v_r && (rv != rblank)) begin
      case (rd_sp_r)
        spce_pkg::SP_CODE: wst_nxt = wst_r | spce_pkg::ST_CODE;
        spce_pkg::SP_DATA: wst_nxt = wst_r | spce_pkg::ST_DATA;
        spce_pkg::SP_ID:   wst_nxt = wst_r | spce_pkg::ST_ID;
        default:           wst_nxt = wst_r | spce_pkg::ST_CFG;
      endcase
    end

    case (state_r)
      spce_pkg::ENG_CLEAR: begin
        code_we    = {1'b0, clr_r} < (CLR_W_L+1)'(spce_pkg::CODE_DEPTH);
        code_waddr = clr_r[CAW-1:0];
        code_wdata = 16'h0;
        data_we    = {1'b0, clr_r} < (CLR_W_L+1)'(spce_pkg::DATA_DEPTH);
        data_waddr = clr_r[DAW-1:0];
        data_wdata = 8'h0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == CLR_W_L'(spce_pkg::CLR_DEPTH - 1)) begin
          state_nxt = spce_pkg::ENG_READY;
        end
      end

      spce_pkg::ENG_READY: begin
        if (op_valid) begin
          op_pop   = 1'b1;
          ocnt_nxt = 3'd0;
          if (op.item.kind) begin
            case (phase_r)
              spce_pkg::PH_RD_HI, spce_pkg::PH_RD_DATA: begin
                if (wl_r == 16'h0) begin
                  obuf_nxt[0] = mk(spce_pkg::RB_STATUS_OK, 1'b1);
                  ocnt_nxt    = 3'd1;
                  phase_nxt   = spce_pkg::PH_IDLE;
                end else begin
                  wl_nxt    = wl_r - 16'd1;
                  state_nxt = spce_pkg::ENG_RDWAIT;
                  rd_sp_nxt = (phase_r == spce_pkg::PH_RD_DATA) ? spce_pkg::SP_DATA : sp_r;
                  if (phase_r == spce_pkg::PH_RD_HI) phase_nxt = spce_pkg::PH_RD_LO;
                  case (rd_sp_nxt)
                    spce_pkg::SP_CODE: begin
                      rd_inr_nxt = inr_c;
                      cptr_nxt   = cptr_r + 24'd1;
                    end
                    spce_pkg::SP_DATA: begin
                      rd_inr_nxt = inr_d;
                      dptr_nxt   = dptr_r + 16'd1;
                    end
                    spce_pkg::SP_ID: begin
                      rd_inr_nxt = inr_i;
                      rd_ix_nxt  = iptr_r;
                      iptr_nxt   = iptr_r + 8'd1;
                    end
                    default: begin
                      rd_inr_nxt = inr_f;
                      rd_ix_nxt  = fptr_r[7:0];
                      fptr_nxt   = fptr_r + 24'd1;
                    end
                  endcase
                end
              end
              spce_pkg::PH_RD_LO: begin
                obuf_nxt[0] = mk(pend_r, 1'b0);
                ocnt_nxt    = 3'd1;
                phase_nxt   = spce_pkg::PH_RD_HI;
              end
              default: ;
            endcase
          end else begin
            case (phase_r)
              spce_pkg::PH_IDLE: begin
                pc_nxt      = 6'd0;
                obuf_nxt[0] = mk(b, 1'b0);
                ocnt_nxt    = 3'd1;
                case (op.cmd)
                  spce_pkg::CMD_BLANK, spce_pkg::CMD_ERASE: begin
                    ocnt_nxt   = 3'd0;
                    werase_nxt = (op.cmd == spce_pkg::CMD_ERASE);
                    wsp_nxt    = spce_pkg::SP_CODE;
                    wix_nxt    = 16'h0;
                    wst_nxt    = 4'h0;
                    state_nxt  = spce_pkg::ENG_WALK;
                  end
                  spce_pkg::CMD_WR_CODE, spce_pkg::CMD_RD_CODE: begin
                    sp_nxt   = spce_pkg::SP_CODE;
                    cptr_nxt = rs_r;
                    wl_nxt   = ccount;
                    phase_nxt = (op.cmd == spce_pkg::CMD_WR_CODE) ? spce_pkg::PH_WR_HI
                                                                  : spce_pkg::PH_RD_HI;
                  end
                  spce_pkg::CMD_RD_DATA, spce_pkg::CMD_WR_DATA: begin
                    sp_nxt    = spce_pkg::SP_DATA;
                    dptr_nxt  = 16'h0;
                    wl_nxt    = dlen_r;
                    phase_nxt = (op.cmd == spce_pkg::CMD_WR_DATA) ? spce_pkg::PH_WR_DATA
                                                                  : spce_pkg::PH_RD_DATA;
                  end
                  spce_pkg::CMD_RD_ID, spce_pkg::CMD_WR_ID: begin
                    sp_nxt    = spce_pkg::SP_ID;
                    iptr_nxt  = 8'h0;
                    wl_nxt    = {8'b0, idlen_r};
                    phase_nxt = (op.cmd == spce_pkg::CMD_WR_ID) ? spce_pkg::PH_WR_HI
                                                                : spce_pkg::PH_RD_HI;
                  end
                  spce_pkg::CMD_RD_CFG, spce_pkg::CMD_WR_CFG: begin
                    sp_nxt    = spce_pkg::SP_CFG;
                    fptr_nxt  = 24'h0;
                    wl_nxt    = {8'b0, cfglen_r};
                    phase_nxt = (op.cmd == spce_pkg::CMD_WR_CFG) ? spce_pkg::PH_WR_HI
                                                                 : spce_pkg::PH_RD_HI;
                  end
                  spce_pkg::CMD_WR_CFG_AT: begin
                    sp_nxt    = spce_pkg::SP_CFG;
                    fptr_nxt  = {1'b0, cfg_off[23:1]};
                    wl_nxt    = rl_r;
                    phase_nxt = spce_pkg::PH_WR_HI;
                  end
                  spce_pkg::CMD_HELLO: begin
                    obuf_nxt[1] = mk(spce_pkg::RB_HELLO_ID, 1'b1);
                    ocnt_nxt    = 3'd2;
                  end
                  spce_pkg::CMD_LOAD_INFO:  phase_nxt = spce_pkg::PH_INFO;
                  spce_pkg::CMD_LOAD_MASKS: phase_nxt = spce_pkg::PH_MASKS;
                  spce_pkg::CMD_PING: begin
                    obuf_nxt[0] = mk(spce_pkg::RB_PING, 1'b1);
                  end
                  spce_pkg::CMD_VERSION: begin
                    obuf_nxt[1] = mk(spce_pkg::RB_VER_MAJOR, 1'b0);
                    obuf_nxt[2] = mk(spce_pkg::RB_VER_MINOR, 1'b0);
                    obuf_nxt[3] = mk(spce_pkg::RB_VER_PATCH, 1'b1);
                    ocnt_nxt    = 3'd4;
                  end
                  spce_pkg::CMD_SET_RANGE: begin
                    rs_nxt    = 24'h0;
                    rl_nxt    = 16'h0;
                    phase_nxt = spce_pkg::PH_RANGE;
                  end
                  default: ocnt_nxt = 3'd0;
                endcase
                // empty write transfer closes at once
                if (wl_nxt == 16'h0 && (phase_nxt == spce_pkg::PH_WR_HI ||
                                        phase_nxt == spce_pkg::PH_WR_DATA)) begin
                  obuf_nxt[1] = mk(spce_pkg::RB_STATUS_OK, 1'b1);
                  ocnt_nxt    = 3'd2;
                  phase_nxt   = spce_pkg::PH_IDLE;
                end
              end
              spce_pkg::PH_RANGE: begin
                if (pc_r < 6'd3) rs_nxt = {rs_r[15:0], b};
                else             rl_nxt = {rl_r[7:0], b};
                pc_nxt      = pc_r + 6'd1;
                obuf_nxt[0] = mk(b, pc_r == 6'd4);
                ocnt_nxt    = 3'd1;
                if (pc_r == 6'd4) phase_nxt = spce_pkg::PH_IDLE;
              end
              spce_pkg::PH_INFO: begin
                if (pc_r < 6'(spce_pkg::INFO_BYTES)) begin
                  pc_nxt = pc_r + 6'd1;
                  case (pc_r)
                    6'd0:  code_len_nxt[15:8] = b;
                    6'd1:  code_len_nxt[7:0]  = b;
                    6'd4:  bcode_nxt[15:8]    = b;
                    6'd5:  bcode_nxt[7:0]     = b;
                    6'd8:  bid_nxt[15:8]      = b;
                    6'd9:  bid_nxt[7:0]       = b;
                    6'd16: bdata_nxt[15:8]    = b;
                    6'd17: bdata_nxt[7:0]     = b;
                    6'd28: idlen_nxt          = b;
                    6'd31: cfglen_nxt         = b;
                    6'd34: dlen_nxt[15:8]     = b;
                    6'd35: dlen_nxt[7:0]      = b;
                    default: ;
                  endcase
                end else begin
                  obuf_nxt[0] = mk(spce_pkg::RB_STATUS_OK, 1'b1);
                  ocnt_nxt    = 3'd1;
                  phase_nxt   = spce_pkg::PH_IDLE;
                end
              end
              spce_pkg::PH_MASKS: begin
                if (pc_r < 6'(2 * spce_pkg::MASK_COUNT)) begin
                  mask_we = 1'b1;
                  pc_nxt  = pc_r + 6'd1;
                end else begin
                  obuf_nxt[0] = mk(spce_pkg::RB_STATUS_OK, 1'b1);
                  ocnt_nxt    = 3'd1;
                  phase_nxt   = spce_pkg::PH_IDLE;
                end
              end
              spce_pkg::PH_WR_HI: begin
                pend_nxt  = b;
                phase_nxt = spce_pkg::PH_WR_LO;
              end
              spce_pkg::PH_WR_LO: begin
                case (sp_r)
                  spce_pkg::SP_CODE: begin
                    code_we  = inr_c;
                    cptr_nxt = cptr_r + 24'd1;
                  end
                  spce_pkg::SP_ID: begin
                    id_we    = inr_i;
                    iptr_nxt = iptr_r + 8'd1;
                  end
                  default: begin
                    cst_we   = inr_f;
                    fptr_nxt = fptr_r + 24'd1;
                  end
                endcase
                obuf_nxt[0] = mk(pend_r, 1'b0);
                obuf_nxt[1] = mk(b, 1'b0);
                ocnt_nxt    = 3'd2;
                wl_nxt      = wl_r - 16'd1;
                phase_nxt   = spce_pkg::PH_WR_HI;
                if (wl_r == 16'd1) begin
                  obuf_nxt[2] = mk(spce_pkg::RB_STATUS_OK, 1'b1);
                  ocnt_nxt    = 3'd3;
                  phase_nxt   = spce_pkg::PH_IDLE;
                end
              end
              spce_pkg::PH_WR_DATA: begin
                data_we     = inr_d;
                dptr_nxt    = dptr_r + 16'd1;
                obuf_nxt[0] = mk(b, 1'b0);
                ocnt_nxt    = 3'd1;
                wl_nxt      = wl_r - 16'd1;
                if (wl_r == 16'd1) begin
                  obuf_nxt[1] = mk(spce_pkg::RB_STATUS_OK, 1'b1);
                  ocnt_nxt    = 3'd2;
                  phase_nxt   = spce_pkg::PH_IDLE;
                end
              end
              default: ;
            endcase
          end
          if (state_nxt == spce_pkg::ENG_READY && ocnt_nxt != 3'd0) begin
            state_nxt = spce_pkg::ENG_EMIT;
          end
        end
      end

      spce_pkg::ENG_RDWAIT: begin
        if (rd_sp_r == spce_pkg::SP_DATA) begin
          obuf_nxt[0] = mk(rv[7:0], 1'b0);
        end else begin
          obuf_nxt[0] = mk(rv[15:8], 1'b0);
          pend_nxt    = rv[7:0];
        end
        ocnt_nxt  = 3'd1;
        state_nxt = spce_pkg::ENG_EMIT;
      end

      spce_pkg::ENG_WALK: begin
        code_raddr = wix_r[CAW-1:0];
        data_raddr = wix_r[DAW-1:0];
        code_waddr = wix_r[CAW-1:0];
        code_wdata = bcode_r;
        data_waddr = wix_r[DAW-1:0];
        data_wdata = bdata_r[7:0];
        id_wi      = wix_r[IAW-1:0];
        id_wd      = bid_r;
        cst_wi     = wix_r[FAW-1:0];
        cst_wd     = mask_wk;
        if (wix_r == wn) begin
          wix_nxt = 16'h0;
          case (wsp_r)
            spce_pkg::SP_CODE: wsp_nxt = spce_pkg::SP_DATA;
            spce_pkg::SP_DATA: wsp_nxt = spce_pkg::SP_ID;
            spce_pkg::SP_ID:   wsp_nxt = spce_pkg::SP_CFG;
            default:           state_nxt = spce_pkg::ENG_WFIN;
          endcase
        end else begin
          wix_nxt = wix_r + 16'd1;
          if (werase_r) begin
            case (wsp_r)
              spce_pkg::SP_CODE: code_we = winr;
              spce_pkg::SP_DATA: data_we = winr;
              spce_pkg::SP_ID:   id_we   = winr;
              default:           cst_we  = winr;
            endcase
          end else begin
            chk_v_nxt  = 1'b1;
            rd_sp_nxt  = wsp_r;
            rd_inr_nxt = winr;
            rd_ix_nxt  = wix_r[7:0];
          end
        end
      end

      spce_pkg::ENG_WFIN: begin
        obuf_nxt[0] = mk(werase_r ? spce_pkg::CB_ERASE : spce_pkg::CB_BLANK_CHECK, 1'b0);
        obuf_nxt[1] = mk(werase_r ? spce_pkg::RB_STATUS_OK : {4'b0, wst_r}, 1'b1);
        ocnt_nxt    = 3'd2;
        state_nxt   = spce_pkg::ENG_EMIT;
      end

      spce_pkg::ENG_EMIT: begin
        obuf_nxt[0] = obuf_r[1];
        obuf_nxt[1] = obuf_r[2];
        obuf_nxt[2] = obuf_r[3];
        ocnt_nxt    = ocnt_r - 3'd1;
        if (ocnt_r == 3'd1) state_nxt = spce_pkg::ENG_READY;
      end

      default: state_nxt = spce_pkg::ENG_READY;
    endcase
  end

  assign idle      = (state_r == spce_pkg::ENG_READY);
  assign out_valid = (state_r == spce_pkg::ENG_EMIT);
  assign out_item  = obuf_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= spce_pkg::ENG_CLEAR;
      phase_r    <= spce_pkg::PH_IDLE;
      sp_r       <= spce_pkg::SP_CODE;
      pc_r       <= '0;
      rs_r       <= '0;
      rl_r       <= '0;
      pend_r     <= '0;
      wl_r       <= '0;
      cptr_r     <= '0;
      dptr_r     <= '0;
      iptr_r     <= '0;
      fptr_r     <= '0;
      code_len_r <= '0;
      bcode_r    <= '0;
      bid_r      <= '0;
      bdata_r    <= '0;
      dlen_r     <= '0;
      idlen_r    <= '0;
      cfglen_r   <= '0;
      code_use_r <= 14'(spce_pkg::CODE_DEPTH == 8192 ? 8192 : 8192);
      data_use_r <= 9'd256;
      id_use_r   <= 4'd4;
      cfgw_use_r <= 5'd2;
      ocnt_r     <= '0;
      werase_r   <= 1'b0;
      wsp_r      <= spce_pkg::SP_CODE;
      wix_r      <= '0;
      wst_r      <= '0;
      chk_v_r    <= 1'b0;
      clr_r      <= '0;
      for (int i = 0; i < spce_pkg::MASK_COUNT; i++) mask_r[i] <= '0;
      for (int i = 0; i < spce_pkg::ID_DEPTH; i++)   id_r[i]   <= '0;
      for (int i = 0; i < spce_pkg::CFG_DEPTH; i++)  cfgs_r[i] <= '0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      sp_r       <= sp_nxt;
      pc_r       <= pc_nxt;
      rs_r       <= rs_nxt;
      rl_r       <= rl_nxt;
      pend_r     <= pend_nxt;
      wl_r       <= wl_nxt;
      cptr_r     <= cptr_nxt;
      dptr_r     <= dptr_nxt;
      iptr_r     <= iptr_nxt;
      fptr_r     <= fptr_nxt;
      code_len_r <= code_len_nxt;
      bcode_r    <= bcode_nxt;
      bid_r      <= bid_nxt;
      bdata_r    <= bdata_nxt;
      dlen_r     <= dlen_nxt;
      idlen_r    <= idlen_nxt;
      cfglen_r   <= cfglen_nxt;
      ocnt_r     <= ocnt_nxt;
      werase_r   <= werase_nxt;
      wsp_r      <= wsp_nxt;
      wix_r      <= wix_nxt;
      wst_r      <= wst_nxt;
      chk_v_r    <= chk_v_nxt;
      clr_r      <= clr_nxt;
      if (cfg_we) begin
        case (cfg_index)
          spce_pkg::REG_CODE_WORDS: code_use_r <= cfg_wdata;
          spce_pkg::REG_DATA_BYTES: data_use_r <= cfg_wdata[8:0];
          spce_pkg::REG_ID_WORDS:   id_use_r   <= cfg_wdata[3:0];
          spce_pkg::REG_CFG_WORDS:  cfgw_use_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (mask_we) begin
        if (mask_hi) mask_r[mask_wi][15:8] <= mask_wb;
        else         mask_r[mask_wi][7:0]  <= mask_wb;
      end
      if (id_we)  id_r[id_wi]    <= id_wd;
      if (cst_we) cfgs_r[cst_wi] <= cst_wd;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    obuf_r   <= obuf_nxt;
    rd_sp_r  <= rd_sp_nxt;
    rd_inr_r <= rd_inr_nxt;
    rd_ix_r  <= rd_ix_nxt;
  end

`ifndef ASSERT_OFF
  a_emit_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spce_pkg::ENG_EMIT) |-> (ocnt_r != 3'd0))
    else $error("emit state with empty output buffer");
  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spce_pkg::ENG_RDWAIT) |=> (state_r == spce_pkg::ENG_EMIT))
    else $error("read result not emitted after one cycle");
  a_end_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.response_end) |=> !out_valid)
    else $error("beat follows the end of a reply");
  a_walk_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spce_pkg::ENG_WFIN) |-> !chk_v_r)
    else $error("blank check compare still pending at walk end");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spce_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned BEATS_PER_SETTING = 70;

  // Scoreboard: mirrors the command engine state and holds the reply bytes
  // still owed by the block, oldest first.
  class reply_scoreboard;
    int unsigned code_reg, data_reg, id_reg, cfg_reg;
    phase_t      phase;
    logic [7:0]  cur_cmd;
    int unsigned pay_cnt;
    logic [23:0] rng_start;
    logic [15:0] rng_len;
    logic [7:0]  held;
    logic [15:0] left;
    logic [23:0] code_ptr;
    logic [15:0] data_ptr;
    logic [7:0]  id_ptr;
    logic [23:0] cfg_ptr;
    logic [7:0]  info[INFO_BYTES];
    logic [15:0] masks[MASK_COUNT];
    logic [15:0] code_mem[CODE_DEPTH];
    logic [7:0]  data_mem[DATA_DEPTH];
    logic [15:0] id_mem[ID_DEPTH];
    logic [15:0] cfg_mem[CFG_DEPTH];
    out_t        reply_q[$];
    int unsigned errors, replies_seen, beats_seen;

    function new();
      code_reg = CODE_DEPTH; data_reg = DATA_DEPTH; id_reg = 4; cfg_reg = 2;
      phase = PH_IDLE; cur_cmd = '0; pay_cnt = 0; rng_start = '0; rng_len = '0;
      held = '0; left = '0; code_ptr = '0; data_ptr = '0; id_ptr = '0; cfg_ptr = '0;
      foreach (info[i]) info[i] = '0;
      foreach (masks[i]) masks[i] = '0;
      foreach (code_mem[i]) code_mem[i] = '0;
      foreach (data_mem[i]) data_mem[i] = '0;
      foreach (id_mem[i]) id_mem[i] = '0;
      foreach (cfg_mem[i]) cfg_mem[i] = '0;
      errors = 0; replies_seen = 0; beats_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [13:0] val);
      case (idx)
        REG_CODE_WORDS: code_reg = val;
        REG_DATA_BYTES: data_reg = val[8:0];
        REG_ID_WORDS:   id_reg = val[3:0];
        default:        cfg_reg = val[4:0];
      endcase
    endfunction

    function int unsigned size_of(int unsigned r, int unsigned depth);
      return (r < depth) ? r : depth;
    endfunction

    function int unsigned info16(int unsigned off);
      return {info[off], info[off + 1]};
    endfunction

    function int unsigned mask_at(int unsigned i);
      return (i < MASK_COUNT) ? masks[i] : 0;
    endfunction

    function space_t space_for(logic [7:0] c);
      if (c == CB_WR_CODE || c == CB_RD_CODE) return SP_CODE;
      if (c == CB_RD_DATA || c == CB_WR_DATA) return SP_DATA;
      if (c == CB_RD_ID || c == CB_WR_ID) return SP_ID;
      return SP_CFG;
    endfunction

    function int unsigned read_word(space_t sp);
      int unsigned r;
      r = 0;
      case (sp)
        SP_CODE: begin
          if (code_ptr < size_of(code_reg, CODE_DEPTH)) r = code_mem[code_ptr];
          code_ptr++;
        end
        SP_DATA: begin
          if (data_ptr < size_of(data_reg, DATA_DEPTH)) r = data_mem[data_ptr];
          data_ptr++;
        end
        SP_ID: begin
          if (id_ptr < size_of(id_reg, ID_DEPTH)) r = id_mem[id_ptr];
          id_ptr++;
        end
        default: begin
          if (cfg_ptr < size_of(cfg_reg, CFG_DEPTH)) r = cfg_mem[cfg_ptr];
          cfg_ptr++;
        end
      endcase
      return r;
    endfunction

    function void write_word(space_t sp, int unsigned v);
      case (sp)
        SP_CODE: begin
          if (code_ptr < size_of(code_reg, CODE_DEPTH)) code_mem[code_ptr] = v[15:0];
          code_ptr++;
        end
        SP_DATA: begin
          if (data_ptr < size_of(data_reg, DATA_DEPTH)) data_mem[data_ptr] = v[7:0];
          data_ptr++;
        end
        SP_ID: begin
          if (id_ptr < size_of(id_reg, ID_DEPTH)) id_mem[id_ptr] = v[15:0];
          id_ptr++;
        end
        default: begin
          if (cfg_ptr < size_of(cfg_reg, CFG_DEPTH)) cfg_mem[cfg_ptr] = v[15:0];
          cfg_ptr++;
        end
      endcase
    endfunction

    function void owe(logic [7:0] b, logic last);
      out_t r;
      r.tx_byte = b;
      r.response_end = last;
      r.target_reset = last;
      reply_q.push_back(r);
    endfunction

    function int unsigned code_span();
      int unsigned len;
      len = info16(0);
      if (rng_start >= len) return 0;
      return (rng_len < len - rng_start) ? rng_len : len - rng_start;
    endfunction

    function logic [7:0] blank_status();
      logic [7:0] st;
      st = '0;
      code_ptr = '0;
      for (int unsigned i = 0; i < info16(0); i++)
        if (read_word(SP_CODE) != info16(4)) st |= ST_CODE;
      data_ptr = '0;
      for (int unsigned i = 0; i < info16(34); i++)
        if (read_word(SP_DATA) != info16(16)) st |= ST_DATA;
      id_ptr = '0;
      for (int unsigned i = 0; i < info[28]; i++)
        if (read_word(SP_ID) != info16(8)) st |= ST_ID;
      cfg_ptr = '0;
      for (int unsigned i = 0; i < info[31]; i++)
        if (read_word(SP_CFG) != mask_at(i)) st |= ST_CFG;
      return st;
    endfunction

    function void erase_all();
      code_ptr = '0;
      for (int unsigned i = 0; i < info16(0); i++) write_word(SP_CODE, info16(4));
      data_ptr = '0;
      for (int unsigned i = 0; i < info16(34); i++) write_word(SP_DATA, info16(16));
      id_ptr = '0;
      for (int unsigned i = 0; i < info[28]; i++) write_word(SP_ID, info16(8));
      cfg_ptr = '0;
      for (int unsigned i = 0; i < info[31]; i++) write_word(SP_CFG, mask_at(i));
    endfunction

    // empty write transfers close at once; empty reads close on the first slot
    function void open_xfer(phase_t ph);
      if (left == 0 && (ph == PH_WR_HI || ph == PH_WR_DATA)) begin
        owe(RB_STATUS_OK, 1'b1);
        phase = PH_IDLE;
      end else begin
        phase = ph;
      end
    endfunction

    function void start_cmd(logic [7:0] b);
      logic [23:0] off;
      cur_cmd = b;
      pay_cnt = 0;
      case (b)
        CB_BLANK_CHECK: begin owe(b, 0); owe(blank_status(), 1); end
        CB_WR_CODE: begin owe(b, 0); code_ptr = rng_start; left = code_span(); open_xfer(PH_WR_HI); end
        CB_RD_CODE: begin owe(b, 0); code_ptr = rng_start; left = code_span(); open_xfer(PH_RD_HI); end
        CB_RD_DATA: begin owe(b, 0); data_ptr = '0; left = info16(34); open_xfer(PH_RD_DATA); end
        CB_RD_ID:   begin owe(b, 0); id_ptr = '0; left = info[28]; open_xfer(PH_RD_HI); end
        CB_RD_CFG:  begin owe(b, 0); cfg_ptr = '0; left = info[31]; open_xfer(PH_RD_HI); end
        CB_WR_CFG:  begin owe(b, 0); cfg_ptr = '0; left = info[31]; open_xfer(PH_WR_HI); end
        CB_WR_ID:   begin owe(b, 0); id_ptr = '0; left = info[28]; open_xfer(PH_WR_HI); end
        CB_WR_DATA: begin owe(b, 0); data_ptr = '0; left = info16(34); open_xfer(PH_WR_DATA); end
        CB_WR_CFG_AT: begin
          owe(b, 0);
          off = rng_start - CFG_BASE_ADDR;
          cfg_ptr = off >> 1;
          left = rng_len;
          open_xfer(PH_WR_HI);
        end
        CB_HELLO:      begin owe(b, 0); owe(RB_HELLO_ID, 1); end
        CB_LOAD_INFO:  begin owe(b, 0); phase = PH_INFO; end
        CB_LOAD_MASKS: begin owe(b, 0); phase = PH_MASKS; end
        CB_PING:       owe(RB_PING, 1);
        CB_VERSION: begin
          owe(b, 0); owe(RB_VER_MAJOR, 0); owe(RB_VER_MINOR, 0); owe(RB_VER_PATCH, 1);
        end
        CB_SET_RANGE: begin rng_start = '0; rng_len = '0; owe(b, 0); phase = PH_RANGE; end
        CB_ERASE: begin owe(b, 0); erase_all(); owe(RB_STATUS_OK, 1); end
        default: cur_cmd = '0;
      endcase
    endfunction

    function void note_beat(in_t it);
      logic [7:0]  b;
      int unsigned w;
      b = it.rx_byte;
      beats_seen++;
      if (it.kind) begin
        if (phase == PH_RD_HI || phase == PH_RD_DATA) begin
          if (left == 0) begin
            owe(RB_STATUS_OK, 1);
            phase = PH_IDLE;
          end else if (phase == PH_RD_DATA) begin
            owe(read_word(SP_DATA), 0);
            left--;
          end else begin
            w = read_word(space_for(cur_cmd));
            held = w[7:0];
            owe(w[15:8], 0);
            left--;
            phase = PH_RD_LO;
          end
        end else if (phase == PH_RD_LO) begin
          owe(held, 0);
          phase = PH_RD_HI;
        end
        return;
      end
      case (phase)
        PH_IDLE: start_cmd(b);
        PH_RANGE: begin
          if (pay_cnt < 3) rng_start = {rng_start[15:0], b};
          else rng_len = {rng_len[7:0], b};
          pay_cnt++;
          owe(b, pay_cnt >= 5);
          if (pay_cnt >= 5) phase = PH_IDLE;
        end
        PH_INFO: begin
          if (pay_cnt < INFO_BYTES) begin
            info[pay_cnt] = b;
            pay_cnt++;
          end else begin
            owe(RB_STATUS_OK, 1);
            phase = PH_IDLE;
          end
        end
        PH_MASKS: begin
          if (pay_cnt < 2 * MASK_COUNT) begin
            if (pay_cnt[0] == 1'b0) masks[pay_cnt >> 1][15:8] = b;
            else masks[pay_cnt >> 1][7:0] = b;
            pay_cnt++;
          end else begin
            owe(RB_STATUS_OK, 1);
            phase = PH_IDLE;
          end
        end
        PH_WR_HI: begin held = b; phase = PH_WR_LO; end
        PH_WR_LO: begin
          write_word(space_for(cur_cmd), {held, b});
          owe(held, 0);
          owe(b, 0);
          left--;
          if (left == 0) begin owe(RB_STATUS_OK, 1); phase = PH_IDLE; end
          else phase = PH_WR_HI;
        end
        PH_WR_DATA: begin
          write_word(SP_DATA, b);
          owe(b, 0);
          left--;
          if (left == 0) begin owe(RB_STATUS_OK, 1); phase = PH_IDLE; end
        end
        default: ;
      endcase
    endfunction

    function void check(out_t got);
      out_t want;
      replies_seen++;
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply beat, got %h", $time, got);
        return;
      end
      want = reply_q.pop_front();
      if (got.tx_byte !== want.tx_byte) begin
        errors++;
        $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte, got.tx_byte);
      end
      if (got.response_end !== want.response_end) begin
        errors++;
        $display("%0t: response_end expected %b actual %b", $time,
                 want.response_end, got.response_end);
      end
      if (got.target_reset !== want.target_reset) begin
        errors++;
        $display("%0t: target_reset expected %b actual %b", $time,
                 want.target_reset, got.target_reset);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_item;
  logic        out_valid;
  out_t        out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_wdata;

  reply_scoreboard sb;
  int unsigned     cycles;
  bit              no_gaps;   // burst stretches with no idling on the input side

  serial_programmer_command_engine_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Replies cannot be stalled: every strobed beat is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_item);
  end

  // Watchdog. Worst case is dominated by the clearing pass and by blank
  // check / erase walks over an 8 K code space.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d reply beats still owed", $time, sb.reply_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One beat: hold start until the block takes it (start high, busy low at the
  // edge), tell the scoreboard, then idle for a random gap.
  task automatic send_beat(in_t it);
    int unsigned gap;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_beat(it);
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_rx(logic [7:0] b);
    in_t it;
    it.kind = 1'b0;
    it.rx_byte = b;
    send_beat(it);
  endtask

  task automatic send_slot();
    in_t it;
    it.kind = 1'b1;
    it.rx_byte = $urandom;
    send_beat(it);
  endtask

  // Picks the next beat from the mirrored protocol phase, so most traffic is
  // well-formed command sequences with random content. Lengths in the info
  // block are kept small most of the time so walks and drains stay short.
  function automatic in_t pick_beat();
    in_t         it;
    logic [7:0]  cmds[17];
    cmds = '{CB_BLANK_CHECK, CB_WR_CODE, CB_RD_CODE, CB_RD_DATA, CB_RD_ID, CB_RD_CFG,
             CB_WR_CFG, CB_WR_ID, CB_WR_DATA, CB_WR_CFG_AT, CB_HELLO, CB_LOAD_INFO,
             CB_LOAD_MASKS, CB_PING, CB_VERSION, CB_SET_RANGE, CB_ERASE};
    it.kind = 1'b0;
    it.rx_byte = $urandom;
    case (sb.phase)
      PH_IDLE: begin
        if ($urandom_range(0, 9) == 0) it.kind = $urandom_range(0, 1);  // noise
        else it.rx_byte = cmds[$urandom_range(0, 16)];
      end
      PH_RD_HI, PH_RD_LO, PH_RD_DATA: it.kind = ($urandom_range(0, 7) != 0);
      PH_INFO: begin
        case (sb.pay_cnt)
          0:      it.rx_byte = ($urandom_range(0, 15) == 0) ? 8'h20 : 8'h00;
          1, 35:  it.rx_byte = $urandom_range(0, 40);
          34:     it.rx_byte = ($urandom_range(0, 19) == 0) ? 8'h01 : 8'h00;
          16:     it.rx_byte = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : 0;
          28, 31: it.rx_byte = $urandom_range(0, 20);
          default: ;
        endcase
      end
      PH_RANGE: begin
        case (sb.pay_cnt)
          0: it.rx_byte = ($urandom_range(0, 2) == 0) ? CFG_BASE_ADDR[23:16] :
                          (($urandom_range(0, 3) == 0) ? $urandom : 8'h00);
          1: it.rx_byte = ($urandom_range(0, 3) == 0) ? $urandom : 8'h00;
          2: it.rx_byte = $urandom_range(0, 60);
          3: it.rx_byte = 8'h00;
          default: it.rx_byte = $urandom_range(0, 24);
        endcase
      end
      PH_WR_HI, PH_WR_LO, PH_WR_DATA: it.kind = ($urandom_range(0, 9) == 0);
      default: ;
    endcase
    return it;
  endfunction

  task automatic write_sizes(logic [13:0] code_n, logic [13:0] data_n,
                             logic [13:0] id_n, logic [13:0] cfg_n);
    logic [13:0] vals[4];
    vals = '{code_n, data_n, id_n, cfg_n};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= i[1:0];
      cfg_wdata <= vals[i];
      sb.set_reg(i[1:0], vals[i]);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Lets the block drain everything owed, then a short settle for beats
  // that produce nothing.
  task automatic settle();
    start <= 1'b0;
    while (sb.reply_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    sb        = new();
    cycles    = 0;
    no_gaps   = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_CODE_WORDS;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fixed replies, ignored bytes, empty transfers, range echo
    send_rx(CB_PING);
    send_rx(CB_HELLO);
    send_rx(CB_VERSION);
    send_rx(8'h00);            // unknown command
    send_rx(8'hFF);
    send_slot();               // slot with nothing to drain
    send_rx(CB_RD_CODE);       // empty read: status on first slot
    send_slot();
    send_rx(CB_WR_CODE);       // empty write: status right after header
    send_rx(CB_BLANK_CHECK);
    send_rx(CB_ERASE);
    send_rx(CB_SET_RANGE);
    send_rx(8'h30); send_rx(8'h00); send_rx(8'h04); send_rx(8'h00); send_rx(8'h03);
    send_rx(CB_WR_CFG_AT);     // lands beyond the configured cfg size: dropped
    for (int i = 0; i < 6; i++) send_rx(8'hA5 ^ i[7:0]);
    settle();

    // random traffic under several size settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_sizes(14'd8192, 14'd256, 14'd4, 14'd2);
        1: write_sizes(14'd0, 14'd0, 14'd0, 14'd0);
        2: write_sizes(14'h3FFF, 14'h1FF, 14'hF, 14'h1F);
        3: write_sizes(14'd8192, 14'd256, 14'd8, 14'd16);
        default: write_sizes($urandom_range(0, 64), $urandom_range(0, 300),
                             $urandom_range(0, 8), $urandom_range(0, 16));
      endcase
      for (int n = 0; n < BEATS_PER_SETTING; n++) begin
        if (n % 16 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_beat(pick_beat());
      end
      // finish the command in flight so the size change sees an idle block
      while (sb.phase != PH_IDLE) send_beat(pick_beat());
      no_gaps = 1'b0;
      settle();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d input beats, %0d reply beats, 6 size settings",
             sb.beats_seen, sb.replies_seen);
    $display("all commands, empty transfers, out-of-size accesses and read drains exercised");
    if (sb.errors == 0 && sb.reply_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d reply beats never seen", sb.errors, sb.reply_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== serial_programmer_command_engine_top.f =====
rtl/spce_pkg.sv
rtl/spce_ram.sv
rtl/spce_front.sv
rtl/spce_queue.sv
rtl/spce_engine.sv
rtl/serial_programmer_command_engine_top.sv
bench/tb_top.sv
